/* rtl/mlds_pkg.sv */
// Package for the multi-lens deflection summer: sizes, FSM states,
// datapath op codes and controller/datapath interface structs. No dependencies.
package mlds_pkg;

	localparam int MAX_LENSES  = 256;
	localparam int LENS_AW     = $clog2(MAX_LENSES);
	localparam int CNT_W       = 9;
	localparam int RADII_W     = 36;
	localparam int CENTERS_W   = 32;
	localparam int SQRT_STEPS  = 26;
	localparam int DIV_STEPS   = 18;
	localparam int STEP_W      = 5;

	localparam logic [1:0] REG_CLUSTER_COUNT = 2'd0;
	localparam logic [1:0] REG_ROW_OFFSET    = 2'd1;
	localparam logic [1:0] REG_COL_OFFSET    = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE, S_READ, S_OFS, S_SQ, S_SUM, S_SQRT, S_MUL1, S_MUL2,
		S_MUL3, S_DINIT, S_DIV, S_ACC, S_NEXT, S_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_OFS, OP_SQ, OP_SUM, OP_SQRT, OP_MUL1, OP_MUL2,
		OP_MUL3, OP_DINIT, OP_DIV, OP_ACC, OP_PUBLISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic ss_zero;
	} dp_stat_t;

endpackage

/* rtl/mlds_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mlds_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

/* rtl/mlds_ctrl.sv */
// Controller FSM: sequences entries, sqrt and divide iterations, handshakes.
// Depends on mlds_pkg.
module mlds_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   cmd,
	input  logic [8:0]             cluster_count,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [7:0]             raddr,
	output mlds_pkg::dp_cmd_t      dp_cmd,
	input  mlds_pkg::dp_stat_t     dp_stat
);
	import mlds_pkg::*;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   k_q, n_q;
	logic [STEP_W-1:0]  step_q;
	logic               out_valid_q;
	logic               eval_go, publish;

	assign in_ready  = (state_q == S_IDLE);
	assign eval_go   = in_valid && in_ready && cmd;
	assign publish   = (state_q == S_DONE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign raddr     = k_q[LENS_AW-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (eval_go) begin
					state_d = (cluster_count == '0) ? S_DONE : S_READ;
				end
			end
			S_READ:  state_d = S_OFS;
			S_OFS:   state_d = S_SQ;
			S_SQ:    state_d = S_SUM;
			S_SUM:   state_d = S_SQRT;
			S_SQRT: begin
				if (dp_stat.ss_zero) state_d = S_NEXT;
				else if (step_q == '0) state_d = S_MUL1;
			end
			S_MUL1:  state_d = S_MUL2;
			S_MUL2:  state_d = S_MUL3;
			S_MUL3:  state_d = S_DINIT;
			S_DINIT: state_d = S_DIV;
			S_DIV: begin
				if (step_q == '0) state_d = S_ACC;
			end
			S_ACC:   state_d = S_NEXT;
			S_NEXT:  state_d = (k_q + 1'b1 == n_q) ? S_DONE : S_READ;
			S_DONE: begin
				if (publish) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		dp_cmd.op = OP_NONE;
		unique case (state_q)
			S_IDLE:  dp_cmd.op = eval_go ? OP_LOAD : OP_NONE;
			S_OFS:   dp_cmd.op = OP_OFS;
			S_SQ:    dp_cmd.op = OP_SQ;
			S_SUM:   dp_cmd.op = OP_SUM;
			S_SQRT:  dp_cmd.op = dp_stat.ss_zero ? OP_NONE : OP_SQRT;
			S_MUL1:  dp_cmd.op = OP_MUL1;
			S_MUL2:  dp_cmd.op = OP_MUL2;
			S_MUL3:  dp_cmd.op = OP_MUL3;
			S_DINIT: dp_cmd.op = OP_DINIT;
			S_DIV:   dp_cmd.op = OP_DIV;
			S_ACC:   dp_cmd.op = OP_ACC;
			S_DONE:  dp_cmd.op = publish ? OP_PUBLISH : OP_NONE;
			default: dp_cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			n_q         <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (eval_go) begin
				k_q <= '0;
				n_q <= (cluster_count > CNT_W'(MAX_LENSES)) ? CNT_W'(MAX_LENSES)
				                                             : cluster_count;
			end
			if (state_q == S_NEXT) k_q <= k_q + 1'b1;
			if (state_q == S_SUM) step_q <= STEP_W'(SQRT_STEPS - 1);
			else if (state_q == S_DINIT) step_q <= STEP_W'(DIV_STEPS - 1);
			else if ((state_q == S_SQRT || state_q == S_DIV) && step_q != '0)
				step_q <= step_q - 1'b1;
			if (publish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> (k_q < n_q))
		else $error("entry index past active count");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q)
		else $error("result dropped before transfer");
	a_publish: assert property (@(posedge clk) disable iff (!arst_n)
		publish |=> (out_valid_q && state_q == S_IDLE))
		else $error("publish did not raise out_valid");
`endif
endmodule

/* rtl/mlds_dp.sv */
// Datapath: offsets, squares, bit-serial sqrt, split multiply, restoring
// divide and saturating sums. Depends on mlds_pkg.
module mlds_dp (
	input  logic                          clk,
	input  mlds_pkg::dp_cmd_t             dp_cmd,
	output mlds_pkg::dp_stat_t            dp_stat,
	input  logic signed [23:0]            point_row,
	input  logic signed [23:0]            point_col,
	input  logic signed [15:0]            row_offset,
	input  logic signed [15:0]            col_offset,
	input  logic [mlds_pkg::RADII_W-1:0]  radii,
	input  logic [mlds_pkg::CENTERS_W-1:0] centers,
	output logic signed [31:0]            deflection_row,
	output logic signed [31:0]            deflection_col,
	output logic                          saturated
);
	import mlds_pkg::*;

	logic signed [23:0] pr_q, pc_q;
	logic signed [15:0] ro_q, co_q;
	logic [17:0]        re_q, rc_q;
	logic [24:0]        ai_q, aj_q;
	logic               ni_q, nj_q;
	logic [49:0]        ai2_q, aj2_q;
	logic [35:0]        rc2_q;
	logic [50:0]        ss_q;
	logic [51:0]        d_q;
	logic [51:0]        sq_n_q;
	logic [27:0]        sq_rem_q;
	logic [25:0]        sq_root_q;
	logic [50:0]        pi_q, pj_q;
	logic [43:0]        lo_i_q, lo_j_q;
	logic [42:0]        hi_i_q, hi_j_q;
	logic [52:0]        rem_i_q, rem_j_q;
	logic [17:0]        nl_i_q, nl_j_q;
	logic [17:0]        q_i_q, q_j_q;
	logic signed [31:0] acc_r_q, acc_c_q;
	logic               flag_q;

	logic signed [16:0] cr, cc;
	logic signed [25:0] si, sj;
	logic [27:0]        rem_sh, trial;
	logic [68:0]        num_i, num_j;
	logic [52:0]        sh_i, sh_j;
	logic signed [33:0] sum_r, sum_c;

	assign dp_stat.ss_zero = (ss_q == '0);

	assign cr = 17'(signed'(centers[15:0]))  - 17'(ro_q);
	assign cc = 17'(signed'(centers[31:16])) - 17'(co_q);
	assign si = 26'(pr_q) - 26'(signed'({cr, 8'h00}));
	assign sj = 26'(pc_q) - 26'(signed'({cc, 8'h00}));

	assign rem_sh = {sq_rem_q[25:0], sq_n_q[51:50]};
	assign trial  = {sq_root_q, 2'b01};

	assign num_i = 69'(lo_i_q) + {hi_i_q, 26'h0};
	assign num_j = 69'(lo_j_q) + {hi_j_q, 26'h0};
	assign sh_i  = {rem_i_q[51:0], nl_i_q[17]};
	assign sh_j  = {rem_j_q[51:0], nl_j_q[17]};

	// subtracting the signed term: add magnitude when offset negative
	assign sum_r = ni_q ? 34'(acc_r_q) + 34'(q_i_q) : 34'(acc_r_q) - 34'(q_i_q);
	assign sum_c = nj_q ? 34'(acc_c_q) + 34'(q_j_q) : 34'(acc_c_q) - 34'(q_j_q);

	function automatic logic [32:0] clip(input logic signed [33:0] v);
		logic [32:0] r;
		if (v > 34'sd2147483647) r = {1'b1, 32'h7FFF_FFFF};
		else if (v < -34'sd2147483648) r = {1'b1, 32'h8000_0000};
		else r = {1'b0, v[31:0]};
		return r;
	endfunction

	logic [32:0] clip_r, clip_c;
	assign clip_r = clip(sum_r);
	assign clip_c = clip(sum_c);

	always_ff @(posedge clk) begin
		unique case (dp_cmd.op)
			OP_LOAD: begin
				pr_q    <= point_row;
				pc_q    <= point_col;
				ro_q    <= row_offset;
				co_q    <= col_offset;
				acc_r_q <= '0;
				acc_c_q <= '0;
				flag_q  <= 1'b0;
			end
			OP_OFS: begin
				re_q <= radii[17:0];
				rc_q <= radii[35:18];
				ni_q <= si[25];
				nj_q <= sj[25];
				ai_q <= si[25] ? 25'(-si) : si[24:0];
				aj_q <= sj[25] ? 25'(-sj) : sj[24:0];
			end
			OP_SQ: begin
				ai2_q <= ai_q * ai_q;
				aj2_q <= aj_q * aj_q;
				rc2_q <= rc_q * rc_q;
			end
			OP_SUM: begin
				ss_q      <= 51'(ai2_q) + 51'(aj2_q);
				sq_n_q    <= 52'(ai2_q) + 52'(aj2_q);
				sq_rem_q  <= '0;
				sq_root_q <= '0;
			end
			OP_SQRT: begin
				d_q    <= 52'(ss_q) + 52'(rc2_q);
				sq_n_q <= {sq_n_q[49:0], 2'b00};
				if (rem_sh >= trial) begin
					sq_rem_q  <= rem_sh - trial;
					sq_root_q <= {sq_root_q[24:0], 1'b1};
				end else begin
					sq_rem_q  <= rem_sh;
					sq_root_q <= {sq_root_q[24:0], 1'b0};
				end
			end
			OP_MUL1: begin
				pi_q <= 51'(ai_q) * 51'(sq_root_q);
				pj_q <= 51'(aj_q) * 51'(sq_root_q);
			end
			OP_MUL2: begin
				lo_i_q <= re_q * pi_q[25:0];
				lo_j_q <= re_q * pj_q[25:0];
			end
			OP_MUL3: begin
				hi_i_q <= re_q * pi_q[50:26];
				hi_j_q <= re_q * pj_q[50:26];
			end
			OP_DINIT: begin
				// quotient fits in 18 bits, so the top part is already below d
				rem_i_q <= {2'b00, num_i[68:18]};
				rem_j_q <= {2'b00, num_j[68:18]};
				nl_i_q  <= num_i[17:0];
				nl_j_q  <= num_j[17:0];
				q_i_q   <= '0;
				q_j_q   <= '0;
			end
			OP_DIV: begin
				nl_i_q <= {nl_i_q[16:0], 1'b0};
				nl_j_q <= {nl_j_q[16:0], 1'b0};
				if (sh_i >= 53'(d_q)) begin
					rem_i_q <= sh_i - 53'(d_q);
					q_i_q   <= {q_i_q[16:0], 1'b1};
				end else begin
					rem_i_q <= sh_i;
					q_i_q   <= {q_i_q[16:0], 1'b0};
				end
				if (sh_j >= 53'(d_q)) begin
					rem_j_q <= sh_j - 53'(d_q);
					q_j_q   <= {q_j_q[16:0], 1'b1};
				end else begin
					rem_j_q <= sh_j;
					q_j_q   <= {q_j_q[16:0], 1'b0};
				end
			end
			OP_ACC: begin
				acc_r_q <= clip_r[31:0];
				acc_c_q <= clip_c[31:0];
				flag_q  <= flag_q | clip_r[32] | clip_c[32];
			end
			OP_PUBLISH: begin
				deflection_row <= acc_r_q;
				deflection_col <= acc_c_q;
				saturated      <= flag_q;
			end
			default: ;
		endcase
	end
endmodule

/* rtl/multi_lens_deflection_sum_top.sv */
// Multi-lens softened isothermal sphere deflection summer, top level.
// A write item goes to the lens tables; an evaluate item walks each active entry
// (an entry whose centre meets the point skips the divide); result then held.
// Throughput: one item at a time; the per-entry loop is set by the 26-step sqrt
// and the 18-step divider in the datapath. Reset: arst_n async, control cleared,
// config registers zero, lens tables undefined until written.
module multi_lens_deflection_sum_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               cmd,
	input  logic [7:0]         entry_index,
	input  logic [17:0]        einstein_radius,
	input  logic [17:0]        core_radius,
	input  logic signed [15:0] center_row,
	input  logic signed [15:0] center_col,
	input  logic signed [23:0] point_row,
	input  logic signed [23:0] point_col,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] deflection_row,
	output logic signed [31:0] deflection_col,
	output logic               saturated,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import mlds_pkg::*;

	// config registers
	logic [8:0]         cluster_count_q;
	logic signed [15:0] row_offset_q, col_offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cluster_count_q <= '0;
			row_offset_q    <= '0;
			col_offset_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CLUSTER_COUNT: cluster_count_q <= cfg_data[8:0];
				REG_ROW_OFFSET:    row_offset_q    <= cfg_data;
				REG_COL_OFFSET:    col_offset_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// table write on a write-item transfer
	logic                 tbl_we;
	logic [LENS_AW-1:0]   raddr;
	logic [RADII_W-1:0]   radii_rd;
	logic [CENTERS_W-1:0] centers_rd;
	dp_cmd_t              dp_cmd;
	dp_stat_t             dp_stat;

	assign tbl_we = in_valid && in_ready && !cmd;

	mlds_ram #(.WIDTH(RADII_W), .DEPTH(MAX_LENSES)) u_radii (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (entry_index),
		.wdata ({core_radius, einstein_radius}),
		.raddr (raddr),
		.rdata (radii_rd)
	);

	mlds_ram #(.WIDTH(CENTERS_W), .DEPTH(MAX_LENSES)) u_centers (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (entry_index),
		.wdata ({center_col, center_row}),
		.raddr (raddr),
		.rdata (centers_rd)
	);

	mlds_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cmd           (cmd),
		.cluster_count (cluster_count_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.raddr         (raddr),
		.dp_cmd        (dp_cmd),
		.dp_stat       (dp_stat)
	);

	mlds_dp u_dp (
		.clk            (clk),
		.dp_cmd         (dp_cmd),
		.dp_stat        (dp_stat),
		.point_row      (point_row),
		.point_col      (point_col),
		.row_offset     (row_offset_q),
		.col_offset     (col_offset_q),
		.radii          (radii_rd),
		.centers        (centers_rd),
		.deflection_row (deflection_row),
		.deflection_col (deflection_col),
		.saturated      (saturated)
	);
endmodule
